@@ hdl/s2c_pkg.sv @@
// Shared types, constants and codes of the sparse row-to-column converter.
package s2c_pkg;

	localparam int MAX_NONZEROS = 1024;
	localparam int MAX_COLUMNS  = 256;
	localparam int MAX_ROWS     = 256;
	localparam int VALUE_BITS   = 64;

	localparam int ACT_W  = 2;
	localparam int ROW_W  = 8;
	localparam int COL_W  = 8;
	localparam int CNT_W  = 11;
	localparam int SIZE_W = 9;
	localparam int STAT_W = 2;
	localparam int NZ_AW  = $clog2(MAX_NONZEROS);
	localparam int CA_W   = $clog2(MAX_COLUMNS);
	localparam int SA_W   = $clog2(MAX_COLUMNS + 1);

	localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FINISH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_DONE = 2'd2;

	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	typedef struct packed {
		logic [ACT_W-1:0]      action;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic [VALUE_BITS-1:0] value;
		logic [CNT_W-1:0]      index;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic [CNT_W-1:0]      col_start;
		logic [ROW_W-1:0]      entry_row;
		logic [VALUE_BITS-1:0] entry_value;
		logic [CNT_W-1:0]      entry_count;
	} out_item_t;

	typedef struct packed {
		logic cap;
		logic bad;
		logic ld_chk;
		logic ld_wr;
		logic fn_init;
		logic ps_rd;
		logic ps_wr;
		logic sc_c;
		logic tot_rd;
		logic fin_res;
		logic rd_res;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             reject;
		logic             c_last;
		logic             k_done;
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LD_CHK, S_LD_WR, S_FN_INIT, S_PS_RD, S_PS_WR,
		S_SC_A, S_SC_B, S_SC_C, S_FN_TOT, S_FN_RES, S_RD_A, S_RD_B, S_RESP
	} state_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) r = SIZE_W'(1);
		else if (v > maxv) r = maxv;
		return r;
	endfunction

endpackage

@@ hdl/s2c_if.sv @@
// Valid/ready channel interfaces for items and results.
interface s2c_in_if;
	logic               valid;
	logic               ready;
	s2c_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface s2c_out_if;
	logic                valid;
	logic                ready;
	s2c_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/s2c_ctrl.sv @@
// Controller state machine that sequences loads, conversion and reads.
module s2c_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  s2c_pkg::stat_t  stat,
	output s2c_pkg::cmd_t   cmd
);
	import s2c_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					unique case (stat.action)
						ACT_LOAD:   state_d = S_LD_CHK;
						ACT_FINISH: state_d = S_FN_INIT;
						ACT_READ:   state_d = S_RD_A;
						default: begin
							cmd.bad = 1'b1;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_LD_CHK: begin
				cmd.ld_chk = 1'b1;
				state_d = stat.reject ? S_RESP : S_LD_WR;
			end
			S_LD_WR: begin
				cmd.ld_wr = 1'b1;
				state_d = S_RESP;
			end
			S_FN_INIT: begin
				cmd.fn_init = 1'b1;
				state_d = S_PS_RD;
			end
			S_PS_RD: begin
				cmd.ps_rd = 1'b1;
				state_d = S_PS_WR;
			end
			S_PS_WR: begin
				cmd.ps_wr = 1'b1;
				state_d = stat.c_last ? S_SC_A : S_PS_RD;
			end
			S_SC_A: state_d = stat.k_done ? S_FN_TOT : S_SC_B;
			S_SC_B: state_d = S_SC_C;
			S_SC_C: begin
				cmd.sc_c = 1'b1;
				state_d = S_SC_A;
			end
			S_FN_TOT: begin
				cmd.tot_rd = 1'b1;
				state_d = S_FN_RES;
			end
			S_FN_RES: begin
				cmd.fin_res = 1'b1;
				state_d = S_RESP;
			end
			S_RD_A: state_d = S_RD_B;
			S_RD_B: begin
				cmd.rd_res = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ hdl/s2c_dp.sv @@
// Datapath: entry stores, column counts, start pointers and the result registers.
module s2c_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  s2c_pkg::in_item_t           in_data,
	input  s2c_pkg::cmd_t               cmd,
	input  logic [s2c_pkg::SIZE_W-1:0]  num_rows,
	input  logic [s2c_pkg::SIZE_W-1:0]  num_cols,
	output s2c_pkg::stat_t              stat,
	output s2c_pkg::out_item_t          out_data
);
	import s2c_pkg::*;

	in_item_t item_q;
	logic [CNT_W-1:0] count_q, k_q, sum_q;
	logic [CA_W-1:0]  c_q;
	logic             converted_q;
	logic [MAX_COLUMNS-1:0] fill_vld_q;

	logic [ROW_W-1:0]      in_row_mem [MAX_NONZEROS];
	logic [COL_W-1:0]      in_col_mem [MAX_NONZEROS];
	logic [VALUE_BITS-1:0] in_val_mem [MAX_NONZEROS];
	logic [ROW_W-1:0]      out_row_mem [MAX_NONZEROS];
	logic [VALUE_BITS-1:0] out_val_mem [MAX_NONZEROS];
	logic [CNT_W-1:0]      fill_mem [MAX_COLUMNS];
	logic [CNT_W-1:0]      np_mem [MAX_COLUMNS];
	logic [CNT_W-1:0]      start_mem [MAX_COLUMNS+1];

	logic [ROW_W-1:0]      in_row_rd, out_row_rd;
	logic [COL_W-1:0]      in_col_rd;
	logic [VALUE_BITS-1:0] in_val_rd, out_val_rd;
	logic [CNT_W-1:0]      fill_rd, np_rd, start_rd;

	logic [STAT_W-1:0]     st_q;
	logic [CNT_W-1:0]      cs_q;
	logic [ROW_W-1:0]      er_q;
	logic [VALUE_BITS-1:0] ev_q;
	out_item_t             out_q;

	logic [CNT_W-1:0] eff_cnt, fill_val, ps_f;
	logic [CA_W-1:0]  fill_ra, item_ca, rd_ca;
	logic [SA_W-1:0]  start_ra, start_wa;
	logic [CNT_W-1:0] start_wd, np_wd;
	logic [CA_W-1:0]  np_wa;
	logic             start_we, np_we, ok_c, ok_e;

	assign item_ca = item_q.col[CA_W-1:0];
	assign rd_ca   = in_col_rd[CA_W-1:0];

	// A load after a finish begins a new matrix, so it is judged against an empty store.
	assign eff_cnt = converted_q ? '0 : count_q;

	assign stat.action = in_data.action;
	assign stat.reject = ({1'b0, item_q.row} >= num_rows) || ({1'b0, item_q.col} >= num_cols) ||
		({1'b0, item_q.col} >= SIZE_W'(MAX_COLUMNS)) || (eff_cnt >= CNT_W'(MAX_NONZEROS));
	assign stat.c_last = (c_q == CA_W'(MAX_COLUMNS - 1));
	assign stat.k_done = (k_q >= count_q);

	assign fill_ra  = cmd.ps_rd ? c_q : item_ca;
	assign fill_val = fill_vld_q[item_ca] ? fill_rd : '0;
	assign ps_f     = fill_vld_q[c_q] ? fill_rd : '0;

	assign ok_c = (item_q.index <= CNT_W'(num_cols));
	assign ok_e = (item_q.index < count_q) && (item_q.index < CNT_W'(MAX_NONZEROS));
	assign start_ra = cmd.tot_rd ? num_cols : (ok_c ? item_q.index[SA_W-1:0] : '0);

	always_comb begin
		start_we = 1'b0;
		start_wa = '0;
		start_wd = '0;
		if (cmd.fn_init) begin
			start_we = 1'b1;
		end else if (cmd.ps_wr) begin
			start_we = 1'b1;
			start_wa = SA_W'(c_q) + SA_W'(1);
			start_wd = sum_q + ps_f;
		end
		np_we = cmd.ps_wr || cmd.sc_c;
		np_wa = cmd.ps_wr ? c_q : rd_ca;
		np_wd = cmd.ps_wr ? sum_q : np_rd + CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_wr) begin
			in_row_mem[count_q[NZ_AW-1:0]] <= item_q.row;
			in_col_mem[count_q[NZ_AW-1:0]] <= item_q.col;
			in_val_mem[count_q[NZ_AW-1:0]] <= item_q.value;
			fill_mem[item_ca] <= fill_val + CNT_W'(1);
		end
		in_row_rd <= in_row_mem[k_q[NZ_AW-1:0]];
		in_col_rd <= in_col_mem[k_q[NZ_AW-1:0]];
		in_val_rd <= in_val_mem[k_q[NZ_AW-1:0]];
		fill_rd   <= fill_mem[fill_ra];
		if (cmd.sc_c && (np_rd < CNT_W'(MAX_NONZEROS))) begin
			out_row_mem[np_rd[NZ_AW-1:0]] <= in_row_rd;
			out_val_mem[np_rd[NZ_AW-1:0]] <= in_val_rd;
		end
		out_row_rd <= out_row_mem[item_q.index[NZ_AW-1:0]];
		out_val_rd <= out_val_mem[item_q.index[NZ_AW-1:0]];
		if (np_we) np_mem[np_wa] <= np_wd;
		np_rd <= np_mem[rd_ca];
		if (start_we) start_mem[start_wa] <= start_wd;
		start_rd <= start_mem[start_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			converted_q <= 1'b0;
			fill_vld_q  <= '0;
		end else begin
			if (cmd.ld_chk && converted_q) begin
				count_q     <= '0;
				converted_q <= 1'b0;
				fill_vld_q  <= '0;
			end
			if (cmd.ld_wr) begin
				count_q <= count_q + CNT_W'(1);
				fill_vld_q[item_ca] <= 1'b1;
			end
			if (cmd.fin_res) converted_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= in_data;
			st_q <= cmd.bad ? ST_REJECT : ST_OK;
			cs_q <= '0;
			er_q <= '0;
			ev_q <= '0;
		end
		if (cmd.ld_chk && stat.reject) st_q <= ST_REJECT;
		if (cmd.fn_init) begin
			c_q   <= '0;
			k_q   <= '0;
			sum_q <= '0;
		end
		if (cmd.ps_wr) begin
			c_q   <= c_q + CA_W'(1);
			sum_q <= sum_q + ps_f;
		end
		if (cmd.sc_c) k_q <= k_q + CNT_W'(1);
		if (cmd.fin_res) cs_q <= start_rd;
		if (cmd.rd_res) begin
			if (!converted_q) begin
				st_q <= ST_NOT_DONE;
			end else begin
				st_q <= (!ok_c && !ok_e) ? ST_REJECT : ST_OK;
				cs_q <= ok_c ? start_rd : '0;
				er_q <= ok_e ? out_row_rd : '0;
				ev_q <= ok_e ? out_val_rd : '0;
			end
		end
		if (cmd.out_ld) begin
			out_q.status      <= st_q;
			out_q.col_start   <= cs_q;
			out_q.entry_row   <= er_q;
			out_q.entry_value <= ev_q;
			out_q.entry_count <= count_q;
		end
	end

	assign out_data = out_q;
endmodule

@@ hdl/sparse_row_to_column_convert.sv @@
// Top level of the sparse compressed-row to compressed-column converter.
// Items arrive on cmd, one result per item leaves on rsp; both are valid/ready
// channels and a transfer happens when valid and ready are both high.
// A load (action 0) goes through a check state and a write state to the output
// register, skipping the write when rejected; a read (action 2) goes through
// its read states, a bad action straight to the output register. A finish
// (action 1) walks all 256 columns for the prefix sum, then scatters the loaded
// entries one by one into their columns.
// A new item is accepted as soon as the previous one has its result in the
// output register; if rsp is stalled that result waits there and the next
// item still runs, holding only until the output register is free again.
// Reset clears the entry count, the column count valid bits and the finished
// flag; no clearing pass is needed. num_rows and num_cols sit at byte
// addresses 0 and 4 of the APB port, are clamped to 1..256 on write and
// reset to 256; write them only while the block is idle.
module sparse_row_to_column_convert (
	input  logic                       clk,
	input  logic                       arst_n,
	s2c_in_if.sink                     cmd,
	s2c_out_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import s2c_pkg::*;

	logic [SIZE_W-1:0] num_rows_q, num_cols_q;
	cmd_t  cmd_w;
	stat_t stat_w;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NUM_COLS) ? {23'b0, num_cols_q} : {23'b0, num_rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= SIZE_W'(MAX_ROWS);
			num_cols_q <= SIZE_W'(MAX_COLUMNS);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_NUM_ROWS)
				num_rows_q <= clamp_size(pwdata[SIZE_W-1:0], SIZE_W'(MAX_ROWS));
			else
				num_cols_q <= clamp_size(pwdata[SIZE_W-1:0], SIZE_W'(MAX_COLUMNS));
		end
	end

	s2c_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat_w),
		.cmd       (cmd_w)
	);

	s2c_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (cmd.data),
		.cmd      (cmd_w),
		.num_rows (num_rows_q),
		.num_cols (num_cols_q),
		.stat     (stat_w),
		.out_data (rsp.data)
	);
endmodule

@@ hdl/s2c_checker.sv @@
// Port-level assertions for the converter and the bind that attaches them.
module s2c_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [10:0] rsp_count,
	input logic        pready
);
	import s2c_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_REJECT ||
			rsp_status == ST_NOT_DONE))
		else $error("undefined status code");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= 11'(MAX_NONZEROS))
		else $error("entry count beyond capacity");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port stalled");
endmodule

bind sparse_row_to_column_convert s2c_checker u_s2c_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.data.status),
	.rsp_count  (rsp.data.entry_count),
	.pready     (pready)
);
